@@ rtl/varint_field_record_parser_defines.svh @@
// Assertion macros for the varint field record parser.
// Depends on nothing; included by the top level, which supplies clk and rst_n.
`ifndef VARINT_FIELD_RECORD_PARSER_DEFINES_SVH
`define VARINT_FIELD_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VFRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define VFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vfrp_pkg.sv @@
// Shared types and constants for the varint field record parser.
// Used by vfrp_step and varint_field_record_parser; depends on nothing.
package vfrp_pkg;

  localparam int FIELD_COUNT_BITS_DEF = 16;
  localparam int OUT_TDATA_W          = 64;
  localparam int VARINT_LAST_POS      = 4;   // fifth byte of a varint

  // Byte roles reported on the result channel.
  localparam logic [2:0] ROLE_NAME_LEN  = 3'd0;
  localparam logic [2:0] ROLE_NAME      = 3'd1;
  localparam logic [2:0] ROLE_VALUE_LEN = 3'd2;
  localparam logic [2:0] ROLE_VALUE     = 3'd3;
  localparam logic [2:0] ROLE_UPDATED   = 3'd4;
  localparam logic [2:0] ROLE_EXISTS    = 3'd5;
  localparam logic [2:0] ROLE_IGNORED   = 3'd6;

  // Sticky record error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_OVERLONG  = 2'd2;

  localparam logic MODE_PRODUCTION = 1'b0;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_NAME   = 6'b000010,
    PH_VLEN   = 6'b000100,
    PH_VALUE  = 6'b001000,
    PH_UPD    = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  pos;
    logic [31:0] acc;
    logic [31:0] remaining;
    logic [1:0]  err;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic [15:0] field_number;
    logic        field_end;
    logic        field_exists;
    logic        field_updated;
    logic [31:0] length_value;
    logic        length_done;
    logic        record_end;
    logic [1:0]  error_code;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:     PH_START,
    pos:       3'd0,
    acc:       32'd0,
    remaining: 32'd0,
    err:       ERR_NONE
  };

endpackage

@@ rtl/varint_field_record_parser.sv @@
// Varint length-prefixed field record parser, top level.
// Depends on vfrp_pkg, vfrp_step and varint_field_record_parser_defines.svh.
//
// Usage: a serialized record enters one byte per beat on the in_ stream.
// in_tdata carries the byte, in_tuser says the byte is present (clear only
// to close an empty record), in_tlast ends the record. Every input beat gives
// exactly one output beat that echoes the byte and tags it with its role in
// the field, the field index, field completion flags, any decoded length and
// the sticky error code of the record; out_tlast repeats in_tlast.
// The format is chosen by cfg_wr_en/cfg_wr_data (0 production layout with
// names, 1 consumption layout with exists flags); write it only while idle.
//
// Pipeline: an accepted beat passes through the input register and then the
// result register before it appears on out_.
// Throughput is one beat per clock while out_tready is high: the parse state
// is read and rewritten by the combinational step logic between the two registers.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to the start of a record and selects production layout.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and in_tready drops until out_tready returns.
`include "varint_field_record_parser_defines.svh"

module varint_field_record_parser #(
  parameter int FIELD_COUNT_BITS = vfrp_pkg::FIELD_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,  // format_mode
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,     // [7:0] data_byte
  input  logic                             in_tuser,     // [0] byte_present
  input  logic                             in_tlast,     // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] byte_out, [23:8] field_number, [24] field_end, [25] field_exists,
  // [26] field_updated, [58:27] length_value, [59] length_done,
  // [61:60] error_code, [63:62] zero
  output logic [vfrp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]                       out_tuser,    // [2:0] byte_role
  output logic                             out_tlast     // record_end
);

  // Format register.
  logic mode_r;

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_present_r;
  logic       s1_last_r;
  logic       s1_fire;

  // Parse state carried across bytes of a record.
  vfrp_pkg::parse_state_t   state_r;
  vfrp_pkg::parse_state_t   state_nxt;
  logic [FIELD_COUNT_BITS-1:0] cnt_r;
  logic [FIELD_COUNT_BITS-1:0] cnt_nxt;

  // Result register stage.
  logic              out_valid_r;
  vfrp_pkg::result_t res_nxt;
  vfrp_pkg::result_t res_r;

  // The input stage moves on whenever the result register is empty or drains.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vfrp_pkg::MODE_PRODUCTION;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r    <= in_tdata;
      s1_present_r <= in_tuser;
      s1_last_r    <= in_tlast;
    end
  end

  vfrp_step #(
    .CNT_W (FIELD_COUNT_BITS)
  ) u_step (
    .present   (s1_present_r),
    .data_byte (s1_byte_r),
    .last      (s1_last_r),
    .mode      (mode_r),
    .cur       (state_r),
    .cnt       (cnt_r),
    .nxt       (state_nxt),
    .cnt_nxt   (cnt_nxt),
    .res       (res_nxt)
  );

  // Parse state advances only when a byte leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfrp_pkg::STATE_RESET;
      cnt_r   <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.byte_role;
  assign out_tlast  = res_r.record_end;
  assign out_tdata  = {2'b00,
                       res_r.error_code,
                       res_r.length_done,
                       res_r.length_value,
                       res_r.field_updated,
                       res_r.field_exists,
                       res_r.field_end,
                       res_r.field_number,
                       res_r.byte_out};

  // A decoded length is only ever reported on a length byte.
  `VFRP_ASSERT_NOW(a_len_role, out_valid_r && res_r.length_done, res_r.byte_role == vfrp_pkg::ROLE_NAME_LEN || res_r.byte_role == vfrp_pkg::ROLE_VALUE_LEN, "length reported on a non-length byte")

  // A field can only close on its updated flag or on an absent exists flag.
  `VFRP_ASSERT_NOW(a_end_role, out_valid_r && res_r.field_end, res_r.byte_role == vfrp_pkg::ROLE_UPDATED || res_r.byte_role == vfrp_pkg::ROLE_EXISTS, "field closed on a wrong byte role")

  // The error code never takes the unused encoding.
  `VFRP_ASSERT_NOW(a_err_code, out_valid_r, res_r.error_code != 2'b11, "illegal error code")

  // Ending a record returns the parser to the start of a fresh record.
  `VFRP_ASSERT_NEXT(a_rec_clear, s1_fire && s1_last_r, state_r.phase == vfrp_pkg::PH_START && state_r.pos == 3'd0 && state_r.err == vfrp_pkg::ERR_NONE && cnt_r == '0, "record state not cleared after last beat")

endmodule

@@ rtl/vfrp_step.sv @@
// Combinational next-state and result logic for one record byte.
// Depends on vfrp_pkg; instantiated by varint_field_record_parser.
module vfrp_step #(
  parameter int CNT_W = vfrp_pkg::FIELD_COUNT_BITS_DEF
) (
  input  logic                   present,
  input  logic [7:0]             data_byte,
  input  logic                   last,
  input  logic                   mode,
  input  vfrp_pkg::parse_state_t cur,
  input  logic [CNT_W-1:0]       cnt,
  output vfrp_pkg::parse_state_t nxt,
  output logic [CNT_W-1:0]       cnt_nxt,
  output vfrp_pkg::result_t      res
);

  logic [31:0] acc_add;
  logic [31:0] acc_new;
  logic [31:0] rem_dec;
  logic [CNT_W-1:0] cnt_sat;

  always_comb begin
    case (cur.pos)
      3'd0:    acc_add = {25'd0, data_byte[6:0]};
      3'd1:    acc_add = {18'd0, data_byte[6:0], 7'd0};
      3'd2:    acc_add = {11'd0, data_byte[6:0], 14'd0};
      3'd3:    acc_add = {4'd0, data_byte[6:0], 21'd0};
      default: acc_add = {data_byte[3:0], 28'd0};
    endcase
  end

  assign acc_new = cur.acc | acc_add;
  assign rem_dec = (cur.remaining != 32'd0) ? cur.remaining - 32'd1 : 32'd0;
  // The field count saturates at all ones.
  assign cnt_sat = (cnt != {CNT_W{1'b1}}) ? cnt + 1'b1 : cnt;

  always_comb begin
    nxt                = cur;
    cnt_nxt            = cnt;
    res.byte_out       = present ? data_byte : 8'd0;
    res.byte_role      = vfrp_pkg::ROLE_IGNORED;
    res.field_number   = 16'(cnt);
    res.field_end      = 1'b0;
    res.field_exists   = 1'b0;
    res.field_updated  = 1'b0;
    res.length_value   = 32'd0;
    res.length_done    = 1'b0;
    res.record_end     = last;
    res.error_code     = cur.err;

    if (present && cur.phase != vfrp_pkg::PH_IGNORE) begin
      case (cur.phase)
        vfrp_pkg::PH_NAME, vfrp_pkg::PH_VALUE: begin
          res.byte_role = (cur.phase == vfrp_pkg::PH_NAME) ? vfrp_pkg::ROLE_NAME
                                                           : vfrp_pkg::ROLE_VALUE;
          nxt.remaining = rem_dec;
          if (rem_dec == 32'd0) begin
            nxt.phase = (cur.phase == vfrp_pkg::PH_NAME) ? vfrp_pkg::PH_VLEN
                                                         : vfrp_pkg::PH_UPD;
          end
        end
        default: begin
          // Varint bytes: field start, value length or updated flag.
          case (cur.phase)
            vfrp_pkg::PH_START: res.byte_role = (mode == vfrp_pkg::MODE_PRODUCTION)
                                               ? vfrp_pkg::ROLE_NAME_LEN
                                               : vfrp_pkg::ROLE_EXISTS;
            vfrp_pkg::PH_VLEN:  res.byte_role = vfrp_pkg::ROLE_VALUE_LEN;
            default:            res.byte_role = vfrp_pkg::ROLE_UPDATED;
          endcase
          if (!data_byte[7]) begin
            nxt.pos = 3'd0;
            nxt.acc = 32'd0;
            case (cur.phase)
              vfrp_pkg::PH_START: begin
                if (mode == vfrp_pkg::MODE_PRODUCTION) begin
                  res.length_done  = 1'b1;
                  res.length_value = acc_new;
                  if (acc_new != 32'd0) begin
                    nxt.remaining = acc_new;
                    nxt.phase     = vfrp_pkg::PH_NAME;
                  end else begin
                    nxt.phase = vfrp_pkg::PH_VLEN;
                  end
                end else if (acc_new == 32'd0) begin
                  // Absent field: it ends on its exists flag.
                  res.field_end = 1'b1;
                  cnt_nxt       = cnt_sat;
                  nxt.phase     = vfrp_pkg::PH_START;
                end else begin
                  nxt.phase = vfrp_pkg::PH_VLEN;
                end
              end
              vfrp_pkg::PH_VLEN: begin
                res.length_done  = 1'b1;
                res.length_value = acc_new;
                if (acc_new != 32'd0) begin
                  nxt.remaining = acc_new;
                  nxt.phase     = vfrp_pkg::PH_VALUE;
                end else begin
                  nxt.phase = vfrp_pkg::PH_UPD;
                end
              end
              default: begin
                res.field_end     = 1'b1;
                res.field_exists  = 1'b1;
                res.field_updated = (acc_new != 32'd0);
                cnt_nxt           = cnt_sat;
                nxt.phase         = vfrp_pkg::PH_START;
              end
            endcase
          end else if (cur.pos >= 3'(vfrp_pkg::VARINT_LAST_POS)) begin
            nxt.pos   = 3'd0;
            nxt.acc   = 32'd0;
            nxt.err   = vfrp_pkg::ERR_OVERLONG;
            nxt.phase = vfrp_pkg::PH_IGNORE;
          end else begin
            nxt.pos = cur.pos + 3'd1;
            nxt.acc = acc_new;
          end
        end
      endcase
    end

    res.error_code = nxt.err;
    if (last) begin
      if (nxt.err == vfrp_pkg::ERR_NONE &&
          (nxt.phase != vfrp_pkg::PH_START || nxt.pos != 3'd0)) begin
        res.error_code = vfrp_pkg::ERR_TRUNCATED;
      end
      nxt     = vfrp_pkg::STATE_RESET;
      cnt_nxt = '0;
    end
  end

endmodule

@@ tb/sv/tb_varint_field_record_parser.sv @@
// Self-checking testbench for the varint field record parser.
// Depends on vfrp_pkg and the varint_field_record_parser RTL; reads no files.
`timescale 1ns / 1ps

module tb_varint_field_record_parser;

  // The package names only the production layout; the other value of the
  // one-bit format register selects the consumption layout.
  localparam logic MODE_CONSUMPTION = !vfrp_pkg::MODE_PRODUCTION;

  // Ways of closing a generated record.
  localparam int unsigned END_OPEN    = 0;  // leave the record running
  localparam int unsigned END_ON_BYTE = 1;  // tlast on the final byte
  localparam int unsigned END_ABSENT  = 2;  // extra beat with no byte, tlast set

  localparam logic [15:0] FIELD_MAX   = 16'hFFFF;
  localparam int unsigned QUIET_LIMIT = 500;  // cycles with no beat on either side

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } feed_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic                             cfg_wr_data;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [7:0]                       in_tdata;
  logic                             in_tuser;
  logic                             in_tlast;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [vfrp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]                       out_tuser;
  logic                             out_tlast;

  // Stimulus plumbing: records are built in rec_q, then moved to byte_feed,
  // which the driver empties one beat at a time.
  feed_t             rec_q[$];
  feed_t             byte_feed[$];
  feed_t             feed_next;
  vfrp_pkg::result_t expected_tags[$];
  int unsigned stim_count = 0;
  int unsigned idle_pct   = 0;
  int unsigned in_gap     = 0;
  int unsigned out_gap    = 0;
  int unsigned quiet      = 0;
  int unsigned mismatches = 0;
  logic        in_acc     = 1'b0;

  // Parser state as the testbench sees it, plus its copy of the format register.
  logic             fmt_mode;
  vfrp_pkg::phase_t ps_phase;
  logic [2:0]       ps_pos;
  logic [31:0]      ps_acc;
  logic [31:0]      ps_left;
  logic [15:0]      ps_field;
  logic [1:0]       ps_err;

  varint_field_record_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    ps_phase = vfrp_pkg::PH_START;
    ps_pos   = 3'd0;
    ps_acc   = 32'd0;
    ps_left  = 32'd0;
    ps_field = 16'd0;
    ps_err   = vfrp_pkg::ERR_NONE;
  endfunction

  // The field counter sticks at its top value instead of wrapping.
  function automatic void close_field();
    if (ps_field != FIELD_MAX) begin
      ps_field = ps_field + 16'd1;
    end
    ps_phase = vfrp_pkg::PH_START;
  endfunction

  // Tags one accepted input beat and advances the parser state.
  function automatic vfrp_pkg::result_t tag_byte(logic [7:0] b, logic present, logic last);
    vfrp_pkg::result_t r;
    logic [31:0]       v;
    r = '0;
    r.byte_out     = present ? b : 8'd0;
    r.byte_role    = vfrp_pkg::ROLE_IGNORED;
    r.field_number = ps_field;
    r.record_end   = last;
    if (present && ps_phase != vfrp_pkg::PH_IGNORE) begin
      if (ps_phase == vfrp_pkg::PH_NAME || ps_phase == vfrp_pkg::PH_VALUE) begin
        // Raw name or value bytes just count down the announced length.
        r.byte_role = (ps_phase == vfrp_pkg::PH_NAME) ? vfrp_pkg::ROLE_NAME
                                                      : vfrp_pkg::ROLE_VALUE;
        if (ps_left != 0) begin
          ps_left = ps_left - 32'd1;
        end
        if (ps_left == 0) begin
          if (ps_phase == vfrp_pkg::PH_NAME) begin
            ps_phase = vfrp_pkg::PH_VLEN;
          end else begin
            ps_phase = vfrp_pkg::PH_UPD;
          end
        end
      end else begin
        if (ps_phase == vfrp_pkg::PH_START) begin
          r.byte_role = (fmt_mode == vfrp_pkg::MODE_PRODUCTION) ? vfrp_pkg::ROLE_NAME_LEN
                                                                : vfrp_pkg::ROLE_EXISTS;
        end else if (ps_phase == vfrp_pkg::PH_VLEN) begin
          r.byte_role = vfrp_pkg::ROLE_VALUE_LEN;
        end else begin
          r.byte_role = vfrp_pkg::ROLE_UPDATED;
        end
        // The fifth group lands at bit 28, so its top three bits fall off.
        if (ps_pos < 3'(vfrp_pkg::VARINT_LAST_POS)) begin
          ps_acc = ps_acc | ({25'd0, b[6:0]} << (7 * ps_pos));
        end else begin
          ps_acc = ps_acc | {b[3:0], 28'd0};
        end
        if (!b[7]) begin
          v      = ps_acc;
          ps_pos = 3'd0;
          ps_acc = 32'd0;
          if (ps_phase == vfrp_pkg::PH_START && fmt_mode == vfrp_pkg::MODE_PRODUCTION) begin
            r.length_done  = 1'b1;
            r.length_value = v;
            if (v != 0) begin
              ps_left  = v;
              ps_phase = vfrp_pkg::PH_NAME;
            end else begin
              ps_phase = vfrp_pkg::PH_VLEN;
            end
          end else if (ps_phase == vfrp_pkg::PH_START) begin
            // A zero exists flag is the whole field.
            if (v == 0) begin
              r.field_end = 1'b1;
              close_field();
            end else begin
              ps_phase = vfrp_pkg::PH_VLEN;
            end
          end else if (ps_phase == vfrp_pkg::PH_VLEN) begin
            r.length_done  = 1'b1;
            r.length_value = v;
            if (v != 0) begin
              ps_left  = v;
              ps_phase = vfrp_pkg::PH_VALUE;
            end else begin
              ps_phase = vfrp_pkg::PH_UPD;
            end
          end else begin
            r.field_end     = 1'b1;
            r.field_exists  = 1'b1;
            r.field_updated = (v != 0);
            close_field();
          end
        end else if (ps_pos >= 3'(vfrp_pkg::VARINT_LAST_POS)) begin
          // Continuation bit on the fifth byte: the rest of the record is dead.
          ps_pos   = 3'd0;
          ps_acc   = 32'd0;
          ps_err   = vfrp_pkg::ERR_OVERLONG;
          ps_phase = vfrp_pkg::PH_IGNORE;
        end else begin
          ps_pos = ps_pos + 3'd1;
        end
      end
    end
    // Ending anywhere but cleanly between fields is a truncation, unless an
    // earlier error already stuck.
    if (last && ps_err == vfrp_pkg::ERR_NONE &&
        (ps_phase != vfrp_pkg::PH_START || ps_pos != 0)) begin
      ps_err = vfrp_pkg::ERR_TRUNCATED;
    end
    r.error_code = ps_err;
    if (last) begin
      clear_parse();
    end
    return r;
  endfunction

  function automatic string fmt_beat(vfrp_pkg::result_t r);
    return $sformatf({"byte %02h role %0d field %0d end %b ex %b upd %b ",
                      "len %08h/%b last %b err %0d"},
                     r.byte_out, r.byte_role, r.field_number, r.field_end, r.field_exists,
                     r.field_updated, r.length_value, r.length_done, r.record_end,
                     r.error_code);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic void add_byte(logic [7:0] b, logic present);
    feed_t it;
    it = '{data: b, present: present, last: 1'b0};
    rec_q.insert(rec_q.size(), it);
  endfunction

  // Encodes v in at least nb bytes; padding uses zero groups with the
  // continuation bit set, and a fifth byte carries junk in its dropped bits.
  function automatic void add_varint(logic [31:0] v, int unsigned nb);
    int unsigned need;
    logic [6:0]  grp;
    need = 1;
    while (need < 5 && (v >> (7 * need)) != 0) begin
      need++;
    end
    if (nb < need) begin
      nb = need;
    end
    for (int unsigned i = 0; i < nb; i++) begin
      if (i < 4) begin
        grp = v[7*i +: 7];
      end else begin
        grp = {3'($urandom_range(0, 7)), v[31:28]};
      end
      add_byte({(i != nb - 1), grp}, 1'b1);
    end
  endfunction

  function automatic int unsigned pick_width();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1;
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  function automatic logic [31:0] pick_flag();
    case ($urandom_range(0, 5))
      0, 1: return 32'd0;
      2, 3: return 32'd1;
      4: return $urandom_range(2, 200);
      default: return $urandom;
    endcase
  endfunction

  // Long lengths only get a few bytes; the caller adds no more fields after them.
  function automatic bit add_body(logic [31:0] n);
    int unsigned k;
    k = (n > 16) ? $urandom_range(0, 3) : n;
    repeat (k) add_byte(8'($urandom), 1'b1);
    return (n > 16);
  endfunction

  // One field in the layout of mode m; returns 1 when the record must stop.
  function automatic bit add_field(logic m);
    logic [31:0] n;
    if (m == vfrp_pkg::MODE_PRODUCTION) begin
      n = pick_len();
      add_varint(n, pick_width());
      if (add_body(n)) begin
        return 1'b1;
      end
    end else begin
      n = pick_flag();
      add_varint(n, pick_width());
      if (n == 0) begin
        return 1'b0;
      end
    end
    n = pick_len();
    add_varint(n, pick_width());
    if (add_body(n)) begin
      return 1'b1;
    end
    add_varint(pick_flag(), pick_width());
    return 1'b0;
  endfunction

  // Closes the record in rec_q as asked and hands it to the driver. Beats
  // that carry neither a byte nor an end leave the parse state alone and are not counted.
  function automatic void commit(int unsigned how);
    feed_t it;
    if (how == END_ON_BYTE && rec_q.size() != 0) begin
      it = rec_q.pop_back();
      it.last = 1'b1;
      rec_q.insert(rec_q.size(), it);
    end else if (how != END_OPEN) begin
      it = '{data: 8'($urandom), present: 1'b0, last: 1'b1};
      rec_q.insert(rec_q.size(), it);
    end
    foreach (rec_q[i]) begin
      byte_feed.insert(byte_feed.size(), rec_q[i]);
      if (rec_q[i].present || rec_q[i].last) begin
        stim_count++;
      end
    end
    rec_q.delete();
  endfunction

  // Mostly well-formed records; now and then an empty one, random garbage,
  // an overlong varint, a cut-short record or a stray empty beat.
  function automatic void add_record(logic m, bit open);
    int unsigned kind;
    int unsigned nf;
    int unsigned cut;
    feed_t       noop;
    kind = $urandom_range(0, 15);
    if (kind == 1) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom), 1'b1);
    end else if (kind != 0) begin
      nf = $urandom_range(1, 4);
      for (int unsigned f = 0; f < nf; f++) begin
        if (add_field(m)) begin
          break;
        end
      end
      if (kind == 2) begin
        repeat (5) add_byte({1'b1, 7'($urandom)}, 1'b1);
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b1);
      end else if (kind == 3 && rec_q.size() > 1) begin
        cut = $urandom_range(1, rec_q.size() - 1);
        while (rec_q.size() > cut) begin
          rec_q.delete(rec_q.size() - 1);
        end
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      noop = '{data: 8'($urandom), present: 1'b0, last: 1'b0};
      rec_q.insert($urandom_range(0, rec_q.size()), noop);
    end
    if (open) begin
      commit(END_OPEN);
    end else if ($urandom_range(0, 3) == 0) begin
      commit(END_ABSENT);
    end else begin
      commit(END_ON_BYTE);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Returns once nothing is queued, nothing is offered and every expected
  // beat has come back. Sampled on the rising edge, where the driver is quiet.
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_feed.size() != 0 || in_tvalid || expected_tags.size() != 0);
  endtask

  // The block is idle when this is called, so no beat sees a half-written mode.
  task automatic set_mode(logic m);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    fmt_mode     = m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One stretch of random records under one mode. A record may be left
  // running so that the next mode write lands in the middle of it.
  task automatic run_phase(logic m, int unsigned pct, int unsigned n_items, bit may_stay_open);
    int unsigned stop;
    wait_idle();
    set_mode(m);
    idle_pct = pct;
    stop = stim_count + n_items;
    while (stim_count < stop) begin
      add_record(m, 1'b0);
    end
    if (may_stay_open && $urandom_range(0, 2) == 0) begin
      add_record(m, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver and ready generator, both on the falling edge
  // ---------------------------------------------------------------------------

  // A beat stays on the bus until the rising edge that takes it; in_acc says
  // whether the last edge did.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (in_gap != 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        in_gap    <= $urandom_range(0, 4);
        in_tvalid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
        feed_next  = byte_feed.pop_front();
        in_tdata  <= feed_next.data;
        in_tuser  <= feed_next.present;
        in_tlast  <= feed_next.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap    <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_gap    <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard, on the rising edge
  // ---------------------------------------------------------------------------

  // An accepted input beat is predicted at once; an accepted output beat is
  // matched against the oldest prediction still waiting.
  always @(posedge clk) begin
    vfrp_pkg::result_t got;
    vfrp_pkg::result_t want;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_tags.insert(expected_tags.size(), tag_byte(in_tdata, in_tuser, in_tlast));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.byte_out      = out_tdata[7:0];
      got.field_number  = out_tdata[23:8];
      got.field_end     = out_tdata[24];
      got.field_exists  = out_tdata[25];
      got.field_updated = out_tdata[26];
      got.length_value  = out_tdata[58:27];
      got.length_done   = out_tdata[59];
      got.error_code    = out_tdata[61:60];
      got.byte_role     = out_tuser;
      got.record_end    = out_tlast;
      if (expected_tags.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: output beat with nothing expected: %s", $time, fmt_beat(got));
        end
        mismatches++;
      end else begin
        want = expected_tags.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("%0t: output beat mismatch\n  expected %s\n  actual   %s",
                     $time, fmt_beat(want), fmt_beat(got));
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a healthy run never goes long without a beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_varint_field_record_parser: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    fmt_mode    = vfrp_pkg::MODE_PRODUCTION;
    clear_parse();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed records in the production layout.
    set_mode(vfrp_pkg::MODE_PRODUCTION);
    idle_pct = 20;

    // An empty record: one closing beat with no byte.
    commit(END_ABSENT);

    // A clean field: two name bytes at both byte extremes, a value length
    // written with a padding byte, one value byte, a set updated flag.
    add_byte(8'h02, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'h81, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'h80, 1'b1);
    add_byte(8'h01, 1'b1);
    commit(END_ON_BYTE);

    // Largest name length, with junk in the dropped bits of the fifth byte,
    // then the record ends inside the name and must report truncation.
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h7F, 1'b1);
    add_byte(8'h5A, 1'b1);
    commit(END_ON_BYTE);

    // Overlong varint: the fifth byte still continues, the tail is ignored.
    repeat (5) add_byte(8'h80, 1'b1);
    add_byte(8'h11, 1'b1);
    commit(END_ON_BYTE);

    // Consumption layout: an absent field, then a present one with an empty
    // value, a stray beat without a byte, and a byteless record end.
    wait_idle();
    set_mode(MODE_CONSUMPTION);
    add_byte(8'h00, 1'b1);
    add_byte(8'h01, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'h05, 1'b1);
    add_byte(8'hA5, 1'b0);
    commit(END_ABSENT);

    // Random stretches, alternating layouts and idle rates. Every mode write
    // waits for the pipeline to empty, which also exercises a sender pause.
    run_phase(vfrp_pkg::MODE_PRODUCTION, 30, 70, 1'b1);
    run_phase(MODE_CONSUMPTION,           0, 70, 1'b1);
    run_phase(vfrp_pkg::MODE_PRODUCTION, 10, 70, 1'b1);
    run_phase(MODE_CONSUMPTION,          50, 70, 1'b1);
    run_phase(MODE_CONSUMPTION,          30, 70, 1'b1);
    run_phase(vfrp_pkg::MODE_PRODUCTION, 50, 70, 1'b1);
    run_phase(MODE_CONSUMPTION,          10, 70, 1'b1);

    // Final stretch at full rate with no idling on either side.
    run_phase(vfrp_pkg::MODE_PRODUCTION, 0, 80, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_varint_field_record_parser: PASS");
    end else begin
      $display("tb_varint_field_record_parser: FAIL");
    end
    $finish;
  end

endmodule
